@@ rtl/poker_hand_class_histogram_macros.svh @@
// Assertion macros shared by the checker of the poker hand class histogram.
`ifndef POKER_HAND_CLASS_HISTOGRAM_MACROS_SVH
`define POKER_HAND_CLASS_HISTOGRAM_MACROS_SVH

// Checked at every rising edge outside of reset.
`define PHCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PHCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/phch_pkg.sv @@
// Shared types, constants and the hand classifier of the poker hand class histogram.
package phch_pkg;

  localparam int SymbolBits = 8;
  localparam int CountBits  = 32;
  localparam int HandCards  = 5;
  localparam int NumClasses = 7;
  localparam int QueueDepth = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    CLS_FIVE     = 3'd0,
    CLS_FOUR     = 3'd1,
    CLS_FULL     = 3'd2,
    CLS_THREE    = 3'd3,
    CLS_TWO_PAIR = 3'd4,
    CLS_PAIR     = 3'd5,
    CLS_DISTINCT = 3'd6
  } hand_class_e;

  typedef enum logic {
    BK_COUNT,
    BK_DUMP
  } bk_state_e;

  // One classified hand; dump marks the hand that closes a stream.
  typedef struct packed {
    hand_class_e hand_class;
    logic        dump;
  } hand_entry_t;

  // Maps the number of equal card pairs (out of ten) to the hand class.
  function automatic hand_class_e class_of(input logic [3:0] pairs);
    hand_class_e cls;
    case (pairs)
      4'd10:   cls = CLS_FIVE;
      4'd6:    cls = CLS_FOUR;
      4'd4:    cls = CLS_FULL;
      4'd3:    cls = CLS_THREE;
      4'd2:    cls = CLS_TWO_PAIR;
      4'd1:    cls = CLS_PAIR;
      default: cls = CLS_DISTINCT;
    endcase
    return cls;
  endfunction

endpackage

@@ rtl/phch_front.sv @@
// Front end: collects samples into hands, completes the final hand and classifies it.
module phch_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [phch_pkg::SymbolBits-1:0]   symbol_i,
  input  logic                              end_of_stream_i,
  output logic                              push_o,
  output phch_pkg::hand_entry_t             entry_o,
  input  logic                              q_ready_i
);

  logic [phch_pkg::SymbolBits-1:0] hand_q  [4];
  logic [phch_pkg::SymbolBits-1:0] first_q [4];
  logic [2:0] pos_q, pos_d;
  logic [2:0] capt_q, capt_d;
  logic [2:0] capt_nxt;
  logic [2:0] r;
  logic       accept;
  logic [phch_pkg::SymbolBits-1:0] cards [phch_pkg::HandCards];
  logic [3:0] pairs;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  // Build the five cards. Missing cards of a final partial hand come from the
  // first samples of a long stream, or repeat the hand itself cyclically when
  // the whole stream is shorter than one hand.
  always_comb begin
    r        = pos_q + 3'd1;
    capt_nxt = (capt_q < 3'd5) ? capt_q + 3'd1 : capt_q;
    for (int j = 0; j < phch_pkg::HandCards; j++) begin
      if (3'(j) < pos_q) begin
        cards[j] = hand_q[2'(j)];
      end else if (3'(j) == pos_q) begin
        cards[j] = symbol_i;
      end else if (capt_nxt == 3'd5) begin
        cards[j] = first_q[2'(3'(j) - r)];
      end else begin
        cards[j] = symbol_i;
        for (int k = 0; k < j; k++) begin
          if (3'(j - k) == r) cards[j] = cards[k];
        end
      end
    end
  end

  always_comb begin
    pairs = 4'd0;
    for (int a = 0; a < phch_pkg::HandCards; a++) begin
      for (int b = a + 1; b < phch_pkg::HandCards; b++) begin
        pairs = pairs + 4'(cards[a] == cards[b]);
      end
    end
  end

  assign push_o           = accept && ((r == 3'd5) || end_of_stream_i);
  assign entry_o.hand_class = phch_pkg::class_of(pairs);
  assign entry_o.dump     = end_of_stream_i;

  always_comb begin
    pos_d  = pos_q;
    capt_d = capt_q;
    if (accept) begin
      pos_d  = (end_of_stream_i || (r == 3'd5)) ? 3'd0 : r;
      capt_d = end_of_stream_i ? 3'd0 : capt_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 3'd0;
      capt_q <= 3'd0;
    end else begin
      pos_q  <= pos_d;
      capt_q <= capt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (pos_q < 3'd4)) hand_q[pos_q[1:0]] <= symbol_i;
    if (accept && (capt_q < 3'd4)) first_q[capt_q[1:0]] <= symbol_i;
  end

endmodule

@@ rtl/phch_queue.sv @@
// Short queue of classified hands between the front end and the counter bank.
module phch_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  phch_pkg::hand_entry_t entry_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output phch_pkg::hand_entry_t head_o,
  input  logic                  pop_i
);

  phch_pkg::hand_entry_t mem_q [phch_pkg::QueueDepth];
  logic [phch_pkg::QueuePtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [phch_pkg::QueuePtrBits:0]   cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign ready_o = (cnt_q != (phch_pkg::QueuePtrBits+1)'(phch_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (phch_pkg::QueuePtrBits+1)'(do_push)
                  - (phch_pkg::QueuePtrBits+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

endmodule

@@ rtl/phch_back.sv @@
// Back end: saturating class counters and the seven-count dump sequencer.
module phch_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  phch_pkg::hand_entry_t            head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       hand_class_o,
  output logic [phch_pkg::CountBits-1:0]   class_count_o,
  output logic                             last_of_run_o
);

  phch_pkg::bk_state_e state_q, state_d;
  logic [phch_pkg::CountBits-1:0] cnt_q [phch_pkg::NumClasses];
  logic [phch_pkg::CountBits-1:0] cnt_rd;
  logic [2:0] addr;
  logic [2:0] idx_q;
  logic       load;
  logic       last_idx;
  logic       out_valid_q;
  logic [2:0] out_class_q;
  logic [phch_pkg::CountBits-1:0] out_count_q;
  logic       out_last_q;

  assign last_idx = (idx_q == 3'(phch_pkg::CLS_DISTINCT));

  always_comb begin
    state_d = state_q;
    case (state_q)
      phch_pkg::BK_COUNT: if (q_valid_i && head_i.dump) state_d = phch_pkg::BK_DUMP;
      phch_pkg::BK_DUMP:  if (load && last_idx) state_d = phch_pkg::BK_COUNT;
      default:            state_d = phch_pkg::BK_COUNT;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    load  = 1'b0;
    addr  = 3'(head_i.hand_class);
    case (state_q)
      phch_pkg::BK_COUNT: pop_o = q_valid_i;
      phch_pkg::BK_DUMP: begin
        addr = idx_q;
        load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  assign cnt_rd = cnt_q[addr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= phch_pkg::BK_COUNT;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < phch_pkg::NumClasses; i++) cnt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        idx_q <= 3'd0;
        if (cnt_rd != '1) cnt_q[addr] <= cnt_rd + 1'b1;
      end
      if (load) begin
        cnt_q[addr] <= '0;
        idx_q       <= idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_class_q <= idx_q;
      out_count_q <= cnt_rd;
      out_last_q  <= last_idx;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hand_class_o  = out_class_q;
  assign class_count_o = out_count_q;
  assign last_of_run_o = out_last_q;

endmodule

@@ rtl/poker_hand_class_histogram.sv @@
// Top level of the poker hand class histogram: front end, hand queue and counter bank.
//
//   Channel   Direction  Payload                              Marker
//   s_axis    in         tdata[7:0]  = symbol                 tlast = end_of_stream
//   m_axis    out        tdata[31:0] = class_count            tlast = last_of_run,
//                                                             tuser[2:0] = hand_class
//
// The block accepts one sample per cycle. Each fifth sample, and every sample
// that ends a stream, yields a classified hand that enters a four-entry queue
// in the same transfer; the counter bank takes one hand per cycle from it.
// A hand that ends a stream starts a dump of seven counts, one per cycle while
// the output is not stalled, and the counter bank takes no further hand until
// the seventh count is loaded. Samples are still taken during a dump until the
// queue fills, so the input stalls only when the output does, or when streams
// shorter than about nine samples follow each other closely.
// When the queue is empty, the first count of a dump follows the transfer of the
// last sample through the queue, the dump state and the output register.
// Reset is asynchronous and active low; it clears the hand position, the
// stream sample count, the counters, the queue and the output valid flag.
module poker_hand_class_histogram (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] class_count
  output logic [2:0]  m_axis_tuser_o,   // [2:0] hand_class
  output logic        m_axis_tlast_o
);

  logic                  push;
  logic                  q_ready;
  logic                  q_valid;
  logic                  pop;
  phch_pkg::hand_entry_t entry;
  phch_pkg::hand_entry_t head;

  // Front end: builds and classifies hands from the sample stream.
  phch_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .symbol_i        (s_axis_tdata_i[phch_pkg::SymbolBits-1:0]),
    .end_of_stream_i (s_axis_tlast_i),
    .push_o          (push),
    .entry_o         (entry),
    .q_ready_i       (q_ready)
  );

  // The queue lets the front end keep taking samples during a dump.
  phch_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  // Back end: counts hands per class and sends out the seven counts.
  phch_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .hand_class_o  (m_axis_tuser_o),
    .class_count_o (m_axis_tdata_o),
    .last_of_run_o (m_axis_tlast_o)
  );

endmodule

@@ rtl/phch_checker.sv @@
// Port-level checker of the poker hand class histogram and its bind statement.
`include "poker_hand_class_histogram_macros.svh"

module phch_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  `PHCH_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "output changed while stalled")
  `PHCH_ASSERT(a_last_is_distinct, m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == 3'(phch_pkg::CLS_DISTINCT), "run ended on a class other than all different")
  `PHCH_ASSERT(a_class_order, m_axis_tvalid_o && m_axis_tready_i && (m_axis_tuser_o != 3'(phch_pkg::CLS_DISTINCT)) |=> m_axis_tvalid_o && (m_axis_tuser_o == $past(m_axis_tuser_o) + 3'd1), "dump counts not back to back in class order")
  `PHCH_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid_o, "output valid during reset")

endmodule

bind poker_hand_class_histogram phch_checker u_phch_checker (.*);

@@ test/tb_poker_hand_class_histogram.sv @@
// Testbench for the poker hand class histogram: directed and random streams checked against a predictor.
module tb_poker_hand_class_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 20;
  localparam int MaxReports   = 10;
  localparam int HoldCycles   = 300;

  typedef logic [phch_pkg::SymbolBits-1:0] sym_t;

  // One count of a dump, as the output channel should carry it.
  typedef struct packed {
    phch_pkg::hand_class_e hand_class;
    logic [31:0]           count;
    logic                  last;
  } class_count_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;    // [7:0] symbol
  logic        s_axis_tlast_i;    // end of stream
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;    // [31:0] class_count
  logic [2:0]  m_axis_tuser_o;    // [2:0] hand_class
  logic        m_axis_tlast_o;    // last count of the dump

  poker_hand_class_histogram uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Predictor state: the open hand, the head of the stream and the class tallies.
  sym_t                           hand_cards [4];
  int unsigned                    hand_fill;
  sym_t                           stream_head [4];
  int unsigned                    stream_seen;
  logic [phch_pkg::CountBits-1:0] class_tally [phch_pkg::NumClasses];

  class_count_t pending_counts [$];

  int unsigned mismatches   = 0;
  int unsigned samples_sent = 0;
  int          rx_hold_left = 0;
  bit          idle_en      = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL poker_hand_class_histogram");
    $finish;
  end

  // Classifies a full hand by the number of equal pairs and bumps its tally.
  function automatic void tally_hand(
      input logic [phch_pkg::HandCards-1:0][phch_pkg::SymbolBits-1:0] cards);
    int unsigned pairs;
    phch_pkg::hand_class_e cls;
    pairs = 0;
    for (int a = 0; a < phch_pkg::HandCards; a++)
      for (int b = a + 1; b < phch_pkg::HandCards; b++)
        if (cards[a] == cards[b]) pairs++;
    case (pairs)
      10:      cls = phch_pkg::CLS_FIVE;
      6:       cls = phch_pkg::CLS_FOUR;
      4:       cls = phch_pkg::CLS_FULL;
      3:       cls = phch_pkg::CLS_THREE;
      2:       cls = phch_pkg::CLS_TWO_PAIR;
      1:       cls = phch_pkg::CLS_PAIR;
      default: cls = phch_pkg::CLS_DISTINCT;
    endcase
    if (class_tally[cls] != '1) class_tally[cls] = class_tally[cls] + 1'b1;
  endfunction

  // Advances the predictor by one accepted sample; on the end of a stream the
  // open hand is completed and the seven tallies become expected counts.
  function automatic void take_sample(input sym_t sym, input logic eos);
    logic [phch_pkg::HandCards-1:0][phch_pkg::SymbolBits-1:0] cards;
    int unsigned filled;
    class_count_t due;
    cards = '0;
    if (stream_seen < 4) stream_head[stream_seen] = sym;
    if (stream_seen < 5) stream_seen++;
    for (int j = 0; j < hand_fill; j++) cards[j] = hand_cards[j];
    cards[hand_fill] = sym;
    filled = hand_fill + 1;
    if (filled == phch_pkg::HandCards) begin
      tally_hand(cards);
      hand_fill = 0;
    end else begin
      hand_cards[hand_fill] = sym;
      hand_fill = filled;
      if (eos) begin
        // A short stream wraps onto itself; a longer one borrows its first samples.
        for (int j = filled; j < phch_pkg::HandCards; j++)
          cards[j] = (stream_seen >= 5) ? stream_head[j - filled] : cards[j % filled];
        tally_hand(cards);
      end
    end
    if (eos) begin
      for (int k = 0; k < phch_pkg::NumClasses; k++) begin
        due.hand_class = phch_pkg::hand_class_e'(k);
        due.count      = 32'(class_tally[k]);
        due.last       = (k == phch_pkg::NumClasses - 1);
        pending_counts.insert(pending_counts.size(), due);
        class_tally[k] = '0;
      end
      hand_fill   = 0;
      stream_seen = 0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxReports) $display("mismatch: %s", what);
  endtask

  // Compares one accepted count transfer with the oldest expected count.
  task automatic check_count();
    class_count_t want;
    if (pending_counts.size() == 0) begin
      report_mismatch($sformatf("unexpected count: class %0d count %0d last %0b",
                                m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o));
      return;
    end
    want = pending_counts.pop_front();
    if (m_axis_tuser_o !== want.hand_class)
      report_mismatch($sformatf("hand_class: expected %0d, got %0d",
                                want.hand_class, m_axis_tuser_o));
    if (m_axis_tdata_o !== want.count)
      report_mismatch($sformatf("class_count of class %0d: expected %0d, got %0d",
                                want.hand_class, want.count, m_axis_tdata_o));
    if (m_axis_tlast_o !== want.last)
      report_mismatch($sformatf("last_of_run of class %0d: expected %0b, got %0b",
                                want.hand_class, want.last, m_axis_tlast_o));
  endtask

  // Output side: checks transfers, stalls in random bursts and during a requested hold.
  initial begin : count_receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_count();
      if (rx_hold_left > 0) rx_hold_left--;
      else if (stall_left > 0) stall_left--;
      else if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      m_axis_tready_i <= (rx_hold_left == 0) && (stall_left == 0);
    end
  end

  // Offers one sample, possibly after a random gap, and waits for its transfer.
  task automatic send_sample(input sym_t sym, input logic eos);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sym;
    s_axis_tlast_i  <= eos;
    do @(posedge clk_i); while (!s_axis_tready_o);
    take_sample(sym, eos);
    samples_sent++;
  endtask

  // A stream drawn from a random alphabet of 2, 4, 8 or 256 symbols, so that repeated cards are common.
  task automatic send_random_stream(input int unsigned len);
    sym_t base;
    sym_t spread;
    base = sym_t'($urandom);
    case ($urandom_range(0, 3))
      0:       spread = 8'h01;
      1:       spread = 8'h03;
      2:       spread = 8'h07;
      default: spread = 8'hFF;
    endcase
    for (int i = 0; i < len; i++)
      send_sample(base ^ (sym_t'($urandom) & spread), i == len - 1);
  endtask

  function automatic int unsigned random_length();
    return ($urandom_range(0, 9) < 2) ? $urandom_range(1, 4) : $urandom_range(5, 20);
  endfunction

  // Drops valid and waits until every expected count has been received.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    wait (pending_counts.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Every class, short streams that wrap onto themselves, and a long stream
  // whose last hand is completed from its first samples.
  task automatic test_hand_classes();
    send_sample(8'd200, 1'b1);                                  // one sample: five of a kind
    send_sample(8'd0, 1'b0);   send_sample(8'd255, 1'b1);       // two samples: full house
    send_sample(8'd10, 1'b0);  send_sample(8'd20, 1'b0);
    send_sample(8'd30, 1'b1);                                   // three samples: two pairs
    send_sample(8'd0, 1'b0);   send_sample(8'd0, 1'b0);   send_sample(8'd0, 1'b0);
    send_sample(8'd0, 1'b0);   send_sample(8'd255, 1'b0);       // four of a kind
    send_sample(8'd3, 1'b0);   send_sample(8'd3, 1'b0);   send_sample(8'd3, 1'b0);
    send_sample(8'd9, 1'b0);   send_sample(8'd8, 1'b0);         // three of a kind
    send_sample(8'd1, 1'b0);   send_sample(8'd2, 1'b0);   send_sample(8'd3, 1'b0);
    send_sample(8'd1, 1'b0);   send_sample(8'd255, 1'b1);       // one pair, ends stream
    send_sample(8'd9, 1'b0);   send_sample(8'd8, 1'b0);   send_sample(8'd7, 1'b0);
    send_sample(8'd6, 1'b0);   send_sample(8'd5, 1'b0);         // all different
    send_sample(8'd1, 1'b0);   send_sample(8'd2, 1'b1);         // completed with 9, 8, 7
  endtask

  task automatic test_random_streams();
    int unsigned stop_at;
    stop_at = samples_sent + 30;
    while (samples_sent < stop_at) send_random_stream(random_length());
  endtask

  // The receiver holds off while whole streams keep coming, so the hand queue
  // fills and the input has to stall.
  task automatic test_output_hold();
    wait_drained();
    rx_hold_left = HoldCycles;
    repeat (6) send_random_stream(phch_pkg::HandCards);
  endtask

  // The sender stops in mid stream and again between streams until all counts are in.
  task automatic test_sender_pause();
    wait_drained();
    for (int i = 0; i < 8; i++) send_sample(sym_t'($urandom_range(0, 3)), 1'b0);
    wait_drained();
    send_sample(sym_t'($urandom_range(0, 3)), 1'b1);
    wait_drained();
    send_random_stream(3);
  endtask

  // Closing part with neither side idling.
  task automatic test_back_to_back();
    int unsigned stop_at;
    idle_en = 1'b0;
    stop_at = samples_sent + 12;
    while (samples_sent < stop_at) send_random_stream(random_length());
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    m_axis_tready_i <= 1'b0;
    hand_fill   = 0;
    stream_seen = 0;
    for (int k = 0; k < phch_pkg::NumClasses; k++) class_tally[k] = '0;
    for (int j = 0; j < 4; j++) begin
      hand_cards[j]  = '0;
      stream_head[j] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hand_classes();
    test_random_streams();
    test_output_hold();
    test_sender_pause();
    test_back_to_back();
    wait_drained();

    if (mismatches == 0) begin
      $display("PASS poker_hand_class_histogram");
    end else begin
      $display("FAIL poker_hand_class_histogram");
    end
    $finish;
  end

endmodule
